@@ hdl/hhv_pkg.sv @@
// shared types and constants for the http host value validator
// no dependencies
package hhv_pkg;

  localparam int MaxNameLenDef    = 253;
  localparam int MaxLabelLenDef   = 63;
  localparam int MaxLiteralLenDef = 45;
  localparam int QueueDepth       = 2;

  typedef enum logic [3:0] {
    PH_START    = 4'd0,
    PH_NAME     = 4'd1,
    PH_LIT_OPEN = 4'd2,
    PH_LIT_LEAD = 4'd3,
    PH_LIT_HEX  = 4'd4,
    PH_LIT_QUAD = 4'd5,
    PH_AFTER    = 4'd6,
    PH_PORT     = 4'd7
  } phase_t;

  // byte classification made in the front part
  typedef struct packed {
    logic [7:0] c;
    logic       last;
    logic       none;
    logic       is_dec;
    logic       is_hex;
    logic [3:0] hval;
    logic       is_label;
    logic       is_dot;
    logic       is_colon;
    logic       is_lbr;
    logic       is_rbr;
    logic       is_hyphen;
  } cls_t;

  typedef struct packed {
    logic        host_valid;
    logic        bracketed_literal;
    logic        port_present;
    logic [15:0] port_number;
  } res_t;

endpackage

@@ hdl/hhv_front.sv @@
// front part: accepts request bytes, classifies them, queues them
// depends on hhv_pkg
module hhv_front import hhv_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       last,
  input  logic       no_byte,
  output logic       q_valid,
  input  logic       q_ready,
  output cls_t       q_data
);

  localparam int AW = $clog2(QueueDepth);

  cls_t           mem [QueueDepth];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [AW:0]    count;
  cls_t           cls;
  logic           push;
  logic           pop;

  always_comb begin
    cls.c         = data_byte;
    cls.last      = last;
    cls.none      = no_byte;
    cls.is_dec    = data_byte >= 8'h30 && data_byte <= 8'h39;
    cls.is_hex    = 1'b0;
    cls.hval      = 4'd0;
    if (cls.is_dec) begin
      cls.is_hex = 1'b1;
      cls.hval   = 4'(data_byte - 8'h30);
    end else if (data_byte >= 8'h61 && data_byte <= 8'h66) begin
      cls.is_hex = 1'b1;
      cls.hval   = 4'(data_byte - 8'h57);
    end else if (data_byte >= 8'h41 && data_byte <= 8'h46) begin
      cls.is_hex = 1'b1;
      cls.hval   = 4'(data_byte - 8'h37);
    end
    cls.is_label  = (data_byte >= 8'h41 && data_byte <= 8'h5a) ||
                    (data_byte >= 8'h61 && data_byte <= 8'h7a) || cls.is_dec ||
                    data_byte == 8'h2d || data_byte == 8'h5f || data_byte == 8'h7e;
    cls.is_dot    = data_byte == 8'h2e;
    cls.is_colon  = data_byte == 8'h3a;
    cls.is_lbr    = data_byte == 8'h5b;
    cls.is_rbr    = data_byte == 8'h5d;
    cls.is_hyphen = data_byte == 8'h2d;
  end

  assign in_ready = count != (AW+1)'(QueueDepth);
  assign q_valid  = count != '0;
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;
  assign q_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == AW'(QueueDepth-1)) ? '0 : wr_ptr + 1'b1;
      if (pop) rd_ptr <= (rd_ptr == AW'(QueueDepth-1)) ? '0 : rd_ptr + 1'b1;
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

endmodule

@@ hdl/hhv_back.sv @@
// back part: parse state machine and result register
// depends on hhv_pkg
module hhv_back import hhv_pkg::*; #(
  parameter int MAX_NAME_LEN    = MaxNameLenDef,
  parameter int MAX_LABEL_LEN   = MaxLabelLenDef,
  parameter int MAX_LITERAL_LEN = MaxLiteralLenDef
) (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  output logic q_ready,
  input  cls_t q_data,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);

  phase_t      phase, phase_next;
  logic        failed, failed_next;
  logic [7:0]  name_bytes, name_bytes_next;
  logic [6:0]  label_count, label_count_next;
  logic [7:0]  previous_char, previous_char_next;
  logic [5:0]  literal_length, literal_length_next;
  logic [3:0]  group_count, group_count_next;
  logic [2:0]  hex_digits, hex_digits_next;
  logic        double_colon_seen, double_colon_seen_next;
  logic [7:0]  octet_value, octet_value_next;
  logic [2:0]  octet_index, octet_index_next;
  logic [1:0]  octet_digits, octet_digits_next;
  logic [15:0] port_accum, port_accum_next;
  logic        port_digit_seen, port_digit_seen_next;
  logic        group_closed, group_closed_next;
  logic        dec_ok, dec_ok_next;
  logic        bracket_form, bracket_form_next;
  res_t        res_next;
  logic        take;
  logic [11:0] oct_nv;
  logic [19:0] port_nv;
  logic [3:0]  n_groups;
  logic        close_ok;
  logic        use_hex;

  assign q_ready = !out_valid || out_ready;
  assign take    = q_valid && q_ready;
  assign oct_nv  = {4'd0, octet_value} * 12'd10 + {8'd0, q_data.hval};
  assign port_nv = {4'd0, port_accum} * 20'd10 + {16'd0, q_data.hval};

  // next state
  always_comb begin
    phase_next             = phase;
    failed_next            = failed;
    name_bytes_next        = name_bytes;
    label_count_next       = label_count;
    previous_char_next     = q_data.c;
    literal_length_next    = literal_length;
    group_count_next       = group_count;
    hex_digits_next        = hex_digits;
    double_colon_seen_next = double_colon_seen;
    octet_value_next       = octet_value;
    octet_index_next       = octet_index;
    octet_digits_next      = octet_digits;
    port_accum_next        = port_accum;
    port_digit_seen_next   = port_digit_seen;
    group_closed_next      = group_closed;
    dec_ok_next            = dec_ok;
    bracket_form_next      = bracket_form;
    use_hex                = 1'b0;
    n_groups               = 4'd0;
    close_ok               = 1'b0;
    if (q_data.none) previous_char_next = previous_char;
    if (!q_data.none && !failed) begin
      case (phase)
        PH_START, PH_NAME: begin
          if (phase == PH_START && q_data.is_lbr) begin
            bracket_form_next = 1'b1;
            phase_next        = PH_LIT_OPEN;
          end else if (q_data.is_colon) begin
            if (phase == PH_START || previous_char == 8'h2d) failed_next = 1'b1;
            else phase_next = PH_PORT;
          end else begin
            phase_next = PH_NAME;
            if (32'(name_bytes) >= MAX_NAME_LEN) begin
              failed_next = 1'b1;
            end else begin
              name_bytes_next = name_bytes + 8'd1;
              if (q_data.is_dot) begin
                if (label_count == '0 || previous_char == 8'h2d) failed_next = 1'b1;
                label_count_next = '0;
              end else if (q_data.is_label) begin
                if (label_count == '0 && q_data.is_hyphen) failed_next = 1'b1;
                else if (32'(label_count) >= MAX_LABEL_LEN) failed_next = 1'b1;
                else label_count_next = label_count + 7'd1;
              end else begin
                failed_next = 1'b1;
              end
            end
          end
        end
        PH_LIT_OPEN, PH_LIT_LEAD, PH_LIT_HEX, PH_LIT_QUAD: begin
          if (q_data.is_rbr) begin
            if (phase == PH_LIT_HEX) begin
              if (group_closed) begin
                failed_next = 1'b1;
              end else if (hex_digits != '0 && group_count >= 4'd8) begin
                failed_next = 1'b1;
              end else begin
                n_groups = group_count + ((hex_digits != '0) ? 4'd1 : 4'd0);
                close_ok = 1'b1;
              end
            end else if (phase == PH_LIT_QUAD) begin
              if (octet_index != 3'd4) failed_next = 1'b1;
              else begin
                n_groups = group_count + 4'd2;
                close_ok = 1'b1;
              end
            end else begin
              failed_next = 1'b1;
            end
            if (close_ok) begin
              if (double_colon_seen ? (n_groups >= 4'd8) : (n_groups != 4'd8))
                failed_next = 1'b1;
              else
                phase_next = PH_AFTER;
            end
          end else if (32'(literal_length) >= MAX_LITERAL_LEN) begin
            failed_next = 1'b1;
          end else begin
            literal_length_next = literal_length + 6'd1;
            if (phase == PH_LIT_OPEN) begin
              if (q_data.is_colon) phase_next = PH_LIT_LEAD;
              else begin
                phase_next = PH_LIT_HEX;
                use_hex    = 1'b1;
              end
            end else if (phase == PH_LIT_LEAD) begin
              if (!q_data.is_colon) failed_next = 1'b1;
              else begin
                phase_next = PH_LIT_HEX;
                use_hex    = 1'b1;
              end
            end else if (phase == PH_LIT_HEX) begin
              use_hex = 1'b1;
            end else begin
              // dotted-quad tail
              if (q_data.is_dec) begin
                if (octet_digits != '0 && octet_value == '0) failed_next = 1'b1;
                else if (oct_nv > 12'd255) failed_next = 1'b1;
                else begin
                  octet_value_next = oct_nv[7:0];
                  if (octet_digits == '0) begin
                    if (octet_index >= 3'd4) failed_next = 1'b1;
                    else begin
                      octet_index_next  = octet_index + 3'd1;
                      octet_digits_next = 2'd1;
                    end
                  end
                end
              end else if (q_data.is_dot && octet_digits != '0) begin
                if (octet_index == 3'd4) failed_next = 1'b1;
                else begin
                  octet_value_next  = '0;
                  octet_digits_next = '0;
                end
              end else begin
                failed_next = 1'b1;
              end
            end
            if (use_hex) begin
              if (q_data.is_hex) begin
                if (hex_digits >= 3'd4) failed_next = 1'b1;
                else begin
                  if (!q_data.is_dec) dec_ok_next = 1'b0;
                  else if (dec_ok) begin
                    if (hex_digits != '0 && octet_value == '0) dec_ok_next = 1'b0;
                    else if (oct_nv > 12'd255) dec_ok_next = 1'b0;
                    else octet_value_next = oct_nv[7:0];
                  end
                  hex_digits_next   = hex_digits + 3'd1;
                  group_closed_next = 1'b0;
                end
              end else if (q_data.is_colon) begin
                if (hex_digits == '0) begin
                  if (double_colon_seen) failed_next = 1'b1;
                  else begin
                    double_colon_seen_next = 1'b1;
                    group_closed_next      = 1'b0;
                  end
                end else if (group_count >= 4'd8) begin
                  failed_next = 1'b1;
                end else begin
                  group_count_next  = group_count + 4'd1;
                  hex_digits_next   = '0;
                  group_closed_next = 1'b1;
                end
                if (!failed_next) begin
                  octet_value_next = '0;
                  dec_ok_next      = 1'b1;
                end
              end else if (q_data.is_dot) begin
                if (hex_digits == '0 || !dec_ok || group_count > 4'd6) failed_next = 1'b1;
                else begin
                  phase_next        = PH_LIT_QUAD;
                  octet_index_next  = 3'd1;
                  octet_digits_next = '0;
                  octet_value_next  = '0;
                end
              end else begin
                failed_next = 1'b1;
              end
            end
          end
        end
        PH_AFTER: begin
          if (q_data.is_colon) phase_next = PH_PORT;
          else failed_next = 1'b1;
        end
        PH_PORT: begin
          if (!q_data.is_dec || port_nv > 20'd65535) failed_next = 1'b1;
          else begin
            port_accum_next      = port_nv[15:0];
            port_digit_seen_next = 1'b1;
          end
        end
        default: failed_next = 1'b1;
      endcase
    end
  end

  // verdict from the updated state
  always_comb begin
    res_next = '0;
    if (!failed_next) begin
      case (phase_next)
        PH_NAME: res_next.host_valid = previous_char_next != 8'h2d;
        PH_AFTER: begin
          res_next.host_valid        = 1'b1;
          res_next.bracketed_literal = 1'b1;
        end
        PH_PORT: begin
          if (port_digit_seen_next && port_accum_next != '0) begin
            res_next.host_valid        = 1'b1;
            res_next.bracketed_literal = bracket_form_next;
            res_next.port_present      = 1'b1;
            res_next.port_number       = port_accum_next;
          end
        end
        default: res_next = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (take && q_data.last) out_res <= res_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= q_data.last;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (take && q_data.last)) begin
      phase             <= PH_START;
      failed            <= 1'b0;
      name_bytes        <= '0;
      label_count       <= '0;
      previous_char     <= '0;
      literal_length    <= '0;
      group_count       <= '0;
      hex_digits        <= '0;
      double_colon_seen <= 1'b0;
      octet_value       <= '0;
      octet_index       <= '0;
      octet_digits      <= '0;
      port_accum        <= '0;
      port_digit_seen   <= 1'b0;
      group_closed      <= 1'b0;
      dec_ok            <= 1'b1;
      bracket_form      <= 1'b0;
    end else if (take) begin
      phase             <= phase_next;
      failed            <= failed_next;
      name_bytes        <= name_bytes_next;
      label_count       <= label_count_next;
      previous_char     <= previous_char_next;
      literal_length    <= literal_length_next;
      group_count       <= group_count_next;
      hex_digits        <= hex_digits_next;
      double_colon_seen <= double_colon_seen_next;
      octet_value       <= octet_value_next;
      octet_index       <= octet_index_next;
      octet_digits      <= octet_digits_next;
      port_accum        <= port_accum_next;
      port_digit_seen   <= port_digit_seen_next;
      group_closed      <= group_closed_next;
      dec_ok            <= dec_ok_next;
      bracket_form      <= bracket_form_next;
    end
  end

endmodule

@@ hdl/http_host_value_validator.sv @@
// top level of the http host value validator
// depends on hhv_pkg, hhv_front and hhv_back
// Streams one Host header value a byte per request (no_byte marks an empty
// request) and returns one verdict on the request flagged last: validity,
// bracketed IPv6 form, port presence and port number. A request is taken every
// clock while the queue has room; the last byte is written into the classify
// queue, then the parser takes it and writes the verdict straight into the
// result register. The parser's single-byte state update sets the
// one-byte-per-clock rate while no unread verdict stalls it. A two-entry queue
// between classifier and parser and a result register let either side stall.
module http_host_value_validator import hhv_pkg::*; #(
  parameter int MAX_NAME_LEN    = MaxNameLenDef,
  parameter int MAX_LABEL_LEN   = MaxLabelLenDef,
  parameter int MAX_LITERAL_LEN = MaxLiteralLenDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last,
  input  logic        no_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        host_valid,
  output logic        bracketed_literal,
  output logic        port_present,
  output logic [15:0] port_number
);

  logic q_valid;
  logic q_ready;
  cls_t q_data;
  res_t res;

  // classify bytes and queue them
  hhv_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .last      (last),
    .no_byte   (no_byte),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_data    (q_data)
  );

  // parse and hold the verdict
  hhv_back #(
    .MAX_NAME_LEN    (MAX_NAME_LEN),
    .MAX_LABEL_LEN   (MAX_LABEL_LEN),
    .MAX_LITERAL_LEN (MAX_LITERAL_LEN)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_data    (q_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res)
  );

  assign host_valid        = res.host_valid;
  assign bracketed_literal = res.bracketed_literal;
  assign port_present      = res.port_present;
  assign port_number       = res.port_number;

endmodule
